/* hw/rtl/lphs_pkg.sv */
// Shared constants, item types and queue entry type for the linear-probe hash set.
package lphs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = 11;
  localparam int KEY_BYTES   = 16;
  localparam int LEN_W       = 5;
  localparam int WORD_W      = 32;
  localparam int CNT_W       = 32;

  localparam bit KIND_INSERT = 1'b0;
  localparam bit KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [63:0]       key_low;
    logic [63:0]       key_high;
    logic [LEN_W-1:0]  key_length;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [SIZE_W-1:0] probe_count;
    logic [SIZE_W-1:0] stored_count;
    logic [CNT_W-1:0]  total_probes;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } out_item_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic              kind;
    logic [63:0]       key_low;
    logic [63:0]       key_high;
    logic [LEN_W-1:0]  key_length;
    logic [ADDR_W-1:0] home;
  } q_item_t;

endpackage

/* hw/rtl/lphs_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* hw/rtl/lphs_front.sv */
// Front end: accept item, mask key, hash and reduce modulo table size.
module lphs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  lphs_pkg::in_item_t        in_item,
  input  logic [lphs_pkg::SIZE_W-1:0] size,
  input  logic                      clr_busy,
  output logic                      q_push,
  input  logic                      q_full,
  output lphs_pkg::q_item_t         q_item
);
  import lphs_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fst_t;

  fst_t              st_r, st_nxt;
  logic              kind_r;
  logic [63:0]       lo_r;
  logic [63:0]       hi_r;
  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] sum_r, sum_nxt;
  logic [SIZE_W-1:0] rem_r, rem_nxt;
  logic [4:0]        cnt_r, cnt_nxt;

  logic [LEN_W-1:0]        len_c;
  logic [8*KEY_BYTES-1:0]  key_c;
  logic [WORD_W-1:0]       hash_c;
  logic [SIZE_W:0]         trial;
  logic                    accept;

  assign accept  = in_push && !in_full;
  assign in_full = (st_r != F_IDLE) || clr_busy;

  always_comb begin
    len_c = in_item.key_length;
    if (len_c == '0) len_c = LEN_W'(1);
    if (len_c > LEN_W'(KEY_BYTES)) len_c = LEN_W'(KEY_BYTES);
    key_c = {in_item.key_high, in_item.key_low};
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) >= len_c) key_c[8*b +: 8] = 8'h00;
    end
    hash_c = key_c[31:0] + key_c[63:32] + key_c[95:64] + key_c[127:96];
  end

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    trial   = {rem_r, sum_r[WORD_W-1]};
    if (trial >= {1'b0, size}) trial = trial - {1'b0, size};
    rem_nxt = trial[SIZE_W-1:0];
    sum_nxt = {sum_r[WORD_W-2:0], 1'b0};
    cnt_nxt = cnt_r + 5'd1;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      F_IDLE: if (accept) st_nxt = F_DIV;
      F_DIV:  if (cnt_r == 5'd31) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    case (st_r)
      F_IDLE: begin
        if (accept) begin
          kind_r <= in_item.kind;
          lo_r   <= key_c[63:0];
          hi_r   <= key_c[127:64];
          len_r  <= len_c;
          sum_r  <= hash_c;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end
      F_DIV: begin
        sum_r <= sum_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_nxt;
      end
      default: ;
    endcase
  end

  assign q_push = (st_r == F_PUSH);
  assign q_item = '{kind: kind_r, key_low: lo_r, key_high: hi_r,
                    key_length: len_r, home: rem_r[ADDR_W-1:0]};

`ifndef SYNTHESIS
  a_home_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> ({1'b0, rem_r} < {1'b0, size}))
    else $error("home slot outside table");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == F_IDLE && accept) |=> ##31 (st_r == F_DIV && cnt_r == 5'd31))
    else $error("remainder step count wrong");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !accept)
    else $error("item taken during table clear");
`endif
endmodule

/* hw/rtl/lphs_queue.sv */
// Two-entry queue between front and back.
module lphs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  lphs_pkg::q_item_t  wdata,
  input  logic               pop,
  output logic               empty,
  output lphs_pkg::q_item_t  rdata
);
  import lphs_pkg::*;

  q_item_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) ent_r[wp_r] <= wdata;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue overfilled");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd1) |-> (wp_r != rp_r)) else $error("queue pointers out of step");
  a_ptr_eq: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd1) |-> (wp_r == rp_r)) else $error("queue pointers out of step");
`endif
endmodule

/* hw/rtl/lphs_back.sv */
// Back end: table clear, probe walk, insert, statistics and result register.
module lphs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lphs_pkg::SIZE_W-1:0] size,
  output logic                        clr_busy,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  lphs_pkg::q_item_t           q_item,
  output logic                        out_empty,
  input  logic                        out_pop,
  output lphs_pkg::out_item_t         out_item
);
  import lphs_pkg::*;

  localparam int ENT_W = 64 + 64 + LEN_W;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_READ, B_CHK, B_FIN} bst_t;

  bst_t              st_r;
  q_item_t           cur_r;
  logic [ADDR_W-1:0] pos_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [SIZE_W-1:0] step_r;
  logic [SIZE_W-1:0] probes_r;
  logic              ok_r;
  logic [SIZE_W-1:0] held_r;
  logic [CNT_W-1:0]  ptot_r, hits_r, miss_r;
  logic              out_vld_r;
  out_item_t         out_r;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ENT_W-1:0]  wdata, rdata;
  logic [63:0]       s_lo, s_hi;
  logic [LEN_W-1:0]  s_len;
  logic              s_empty, s_match, last, out_free;
  logic [SIZE_W-1:0] probes_nxt;
  logic [SIZE_W:0]   pos_inc;
  logic [CNT_W:0]    ptot_sum;
  logic [CNT_W-1:0]  ptot_nxt, hits_nxt, miss_nxt;

  assign {s_lo, s_hi, s_len} = rdata;
  assign s_empty    = (s_len == '0);
  assign s_match    = (s_len == cur_r.key_length) && (s_lo == cur_r.key_low) &&
                      (s_hi == cur_r.key_high);
  assign probes_nxt = (cur_r.kind == KIND_SEARCH) ? probes_r + SIZE_W'(1) : probes_r;
  assign last       = (step_r + SIZE_W'(1)) == size;
  assign pos_inc    = {1'b0, SIZE_W'(pos_r)} + (SIZE_W+1)'(1);
  assign out_free   = !out_vld_r || out_pop;

  assign we    = (st_r == B_CLR) ||
                 (st_r == B_CHK && s_empty && cur_r.kind == KIND_INSERT);
  assign waddr = (st_r == B_CLR) ? clr_addr_r : pos_r;
  assign wdata = (st_r == B_CLR) ? '0 : {cur_r.key_low, cur_r.key_high, cur_r.key_length};

  lphs_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (pos_r),
    .rdata (rdata)
  );

  always_comb begin
    ptot_sum = {1'b0, ptot_r} + (CNT_W+1)'(probes_r);
    ptot_nxt = ptot_r;
    hits_nxt = hits_r;
    miss_nxt = miss_r;
    if (cur_r.kind == KIND_SEARCH) begin
      ptot_nxt = ptot_sum[CNT_W] ? '1 : ptot_sum[CNT_W-1:0];
      if (ok_r) begin
        if (hits_r != '1) hits_nxt = hits_r + CNT_W'(1);
      end else begin
        if (miss_r != '1) miss_nxt = miss_r + CNT_W'(1);
      end
    end
  end

  assign q_pop    = (st_r == B_IDLE) && !q_empty;
  assign clr_busy = (st_r == B_CLR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_CLR;
      clr_addr_r <= '0;
      held_r     <= '0;
      ptot_r     <= '0;
      hits_r     <= '0;
      miss_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      case (st_r)
        B_CLR: begin
          clr_addr_r <= clr_addr_r + ADDR_W'(1);
          if (clr_addr_r == ADDR_W'(TABLE_DEPTH - 1)) st_r <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty) begin
            cur_r    <= q_item;
            pos_r    <= q_item.home;
            step_r   <= '0;
            probes_r <= '0;
            ok_r     <= 1'b0;
            // Full table: fail the insert without probing.
            if (q_item.kind == KIND_INSERT && held_r >= size) st_r <= B_FIN;
            else st_r <= B_READ;
          end
        end
        B_READ: st_r <= B_CHK;
        B_CHK: begin
          probes_r <= probes_nxt;
          step_r   <= step_r + SIZE_W'(1);
          if (s_empty) begin
            if (cur_r.kind == KIND_INSERT) begin
              ok_r   <= 1'b1;
              held_r <= held_r + SIZE_W'(1);
            end
            st_r <= B_FIN;
          end else if (s_match) begin
            ok_r <= (cur_r.kind == KIND_SEARCH);
            st_r <= B_FIN;
          end else if (last) begin
            st_r <= B_FIN;
          end else begin
            pos_r <= (pos_inc == {1'b0, size}) ? '0 : pos_inc[ADDR_W-1:0];
            st_r  <= B_READ;
          end
        end
        B_FIN: begin
          if (out_free) begin
            ptot_r    <= ptot_nxt;
            hits_r    <= hits_nxt;
            miss_r    <= miss_nxt;
            out_r     <= '{ok: ok_r, probe_count: probes_r, stored_count: held_r,
                           total_probes: ptot_nxt, hit_count: hits_nxt,
                           miss_count: miss_nxt};
            st_r      <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
      // Load a new result, or drop the one just taken.
      if (st_r == B_FIN && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_empty = !out_vld_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_held_max: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= SIZE_W'(TABLE_DEPTH)) else $error("held key count beyond depth");
  a_held_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> held_r >= $past(held_r)) else $error("held key count fell");
  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CHK) |-> (step_r < size)) else $error("probe walk past table");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_FIN && out_free) |=> !out_empty) else $error("result lost");
`endif
endmodule

/* hw/rtl/linear_probe_hash_set_core.sv */
// Top level: size register, front end, front-to-back queue and back end.
// Flow: the front accepts an item, reduces its hash bit-serially and pushes it to
//   the queue, waiting while it is full; the back pops it, then reads and checks
//   slots (one RAM read each) until the walk ends and registers the result.
// The front's bit-serial remainder and the back's probe loop work on different items.
// Reset (rst_n low, synchronous) clears counters, then the back sweeps the slot
//   RAM with in_full high; config writes are taken throughout.
module linear_probe_hash_set_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  lphs_pkg::in_item_t          in_item,
  output logic                        out_empty,
  input  logic                        out_pop,
  output lphs_pkg::out_item_t         out_item,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::SIZE_W-1:0] cfg_wdata
);
  import lphs_pkg::*;

  logic [SIZE_W-1:0] table_size_r;
  logic [SIZE_W-1:0] size;
  logic              clr_busy, q_push, q_full, q_pop, q_empty;
  q_item_t           q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= SIZE_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // Clamp the slot count to 1..depth.
  always_comb begin
    size = table_size_r;
    if (size == '0) size = SIZE_W'(1);
    if (size > SIZE_W'(TABLE_DEPTH)) size = SIZE_W'(TABLE_DEPTH);
  end

  lphs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .size     (size),
    .clr_busy (clr_busy),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_item   (q_wdata)
  );

  lphs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  lphs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size),
    .clr_busy  (clr_busy),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );
endmodule
